// ===== rtl/upi_pkg.sv =====
// ----------------------------------------------------------------------------
// upi_pkg
// Shared types, constants and the arctangent table for the pose integrator.
// ----------------------------------------------------------------------------
package upi_pkg;

   // request op codes
   localparam logic OP_INTEGRATE = 1'b0;
   localparam logic OP_LOAD      = 1'b1;

   // register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEP       = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_X       = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_Y       = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INITIAL_HEADING = 8'd3;

   localparam logic [15:0] TIME_STEP_RESET = 16'd6554;

   // 8/pi in Q.24, turns rad*dt products into 2^-32 turn units
   localparam int HEAD_SCALE      = 42722830;
   localparam int HEAD_SCALE_FRAC = 24;

   // position step rounding: Q.12 * Q.16 * Q.30 down to Q.16
   localparam logic [5:0] POS_SHIFT = 6'd42;

   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] POS_MIN = 32'h8000_0000;

   // gain-compensated start vector, Q.30
   localparam int CORDIC_START = 652032874;
   localparam int TABLE_LEN    = 24;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_WDT,
      ST_MUL_HEAD,
      ST_RND_HEAD,
      ST_UPD_HEAD,
      ST_COR_POSE,
      ST_WAIT_POSE,
      ST_MUL_X,
      ST_RND_X,
      ST_ACC_X,
      ST_MUL_Y,
      ST_RND_Y,
      ST_ACC_Y,
      ST_COR_QUAT,
      ST_WAIT_QUAT,
      ST_DONE
   } state_type;

   // control and status between sequencer and cordic
   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cordic_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_sts_type;

   // arctangent of 2^-i in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/upi_cordic.sv =====
// ----------------------------------------------------------------------------
// upi_cordic
// Rotation-mode cordic, one micro-rotation per cycle, for sine and cosine of
// a 32 bit turn angle. Results are Q.30, held until the next start.
// ----------------------------------------------------------------------------
module upi_cordic
   import upi_pkg::*;
#(
   parameter int ITERS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cordic_ctl_type      ctl,
   output cordic_sts_type      sts,
   output logic signed [33:0]  cos_out,
   output logic signed [33:0]  sin_out
);

   localparam int IW = $clog2(ITERS);

   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [IW-1:0]      iter_ff, iter_in;
   logic               busy_ff, busy_in;
   logic               fix_ff, fix_in;
   logic               flip_ff, flip_in;
   logic               done_ff, done_in;

   logic               fold;
   logic [31:0]        folded;
   logic signed [33:0] dx, dy;
   logic signed [32:0] step_angle;

   // fold into the right half plane and shift by the iteration index
   always_comb begin
      fold       = ctl.angle[31] ^ ctl.angle[30];
      folded     = {ctl.angle[31] ^ fold, ctl.angle[30:0]};
      dx         = y_ff >>> iter_ff;
      dy         = x_ff >>> iter_ff;
      step_angle = signed'({1'b0, atan_turn(5'(iter_ff))});
   end

   // micro-rotation sequencer
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      fix_in  = fix_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in    = 34'(CORDIC_START);
         y_in    = '0;
         z_in    = signed'({folded[31], folded});
         iter_in = '0;
         busy_in = 1'b1;
         fix_in  = 1'b0;
         flip_in = fold;
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_angle;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_angle;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IW'(ITERS - 1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         // undo the half-turn fold
         if (flip_ff) begin
            x_in = -x_ff;
            y_in = -y_ff;
         end
         fix_in  = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      flip_ff <= flip_in;
   end

   assign sts.busy = busy_ff | fix_ff;
   assign sts.done = done_ff;
   assign cos_out  = x_ff;
   assign sin_out  = y_ff;

endmodule

// ===== rtl/unicycle_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// unicycle_pose_integrator
// Dead-reckoning pose integrator: heading advances by w*dt, then x and y by
// v*dt*cos and v*dt*sin of the new heading, with a half-angle quaternion out.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   op, linear and angular velocity
//  rsp      out        rsp_valid/rsp_ready   pose, quaternion, velocity echo
//  csr      in         csr_valid/csr_ready   register index and data
//
//  An integrate request runs the single cordic unit twice, once for the pose
//  and once for the half angle; a load request runs it once, for the half
//  angle only. No new request is taken until the sequencer is idle again.
//  One shared multiplier and one rounding shifter serve every product.
//  Reset is synchronous; no clearing pass. req_ready is high only when idle.
//  A finished result waits in the output register while the next request
//  is accepted; a stalled rsp holds back only the following result.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator
   import upi_pkg::*;
#(
   parameter int ANGLE_BITS        = 16,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic signed [15:0]          req_linear_velocity,
   input  logic signed [15:0]          req_angular_velocity,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_pos_x,
   output logic signed [31:0]          rsp_pos_y,
   output logic signed [15:0]          rsp_heading,
   output logic signed [15:0]          rsp_quat_z,
   output logic signed [15:0]          rsp_quat_w,
   output logic signed [15:0]          rsp_velocity_echo_linear,
   output logic signed [15:0]          rsp_velocity_echo_angular,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [31:0]                 csr_data
);

   localparam logic [5:0] HEAD_SHIFT = 6'(HEAD_SCALE_FRAC + 32 - ANGLE_BITS);

   // sequencer and request registers
   state_type               state_ff, state_in;
   logic signed [15:0]      v_ff, v_in;
   logic signed [15:0]      w_ff, w_in;

   // csr registers
   logic [15:0]             time_step_ff, time_step_in;
   logic [31:0]             init_x_ff, init_x_in;
   logic [31:0]             init_y_ff, init_y_in;
   logic [15:0]             init_heading_ff, init_heading_in;

   // pose state
   logic signed [31:0]      x_ff, x_in;
   logic signed [31:0]      y_ff, y_in;
   logic [ANGLE_BITS-1:0]   heading_ff, heading_in;

   // arithmetic registers
   logic signed [66:0]      prod_ff, prod_in;
   logic                    mul_en;
   logic signed [31:0]      vdt_ff, vdt_in;
   logic signed [33:0]      rnd_ff, rnd_in;

   // output registers
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      out_x_ff, out_y_ff;
   logic [15:0]             out_heading_ff;
   logic signed [15:0]      out_qz_ff, out_qw_ff, out_v_ff, out_w_ff;
   logic                    out_load;

   // shared unit wiring
   logic signed [32:0]      mul_a;
   logic signed [33:0]      mul_b;
   logic [5:0]              rnd_sh;
   logic signed [66:0]      rnd_half, rnd_neg, rnd_sum, rnd_shifted;
   logic signed [33:0]      acc_base, acc_sum;
   logic [31:0]             acc_sat;
   logic [31:0]             angle32, half_angle, init_angle;
   logic                    accept;

   cordic_ctl_type          cor_ctl;
   cordic_sts_type          cor_sts;
   logic signed [33:0]      cor_cos, cor_sin;

   upi_cordic #(
      .ITERS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cor_ctl),
      .sts     (cor_sts),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   // round half away from zero, then saturate to q1.15
   function automatic logic [15:0] to_q15(input logic signed [33:0] v);
      logic signed [33:0] sum;
      logic signed [33:0] r;
      logic [15:0]        q;
      sum = v + 34'sd16384 - signed'({33'b0, v[33]});
      r   = sum >>> 15;
      if (r[33:15] == {19{r[33]}}) begin
         q = r[15:0];
      end else if (r[33]) begin
         q = 16'h8000;
      end else begin
         q = 16'h7FFF;
      end
      return q;
   endfunction

   // binary angles
   assign angle32    = {heading_ff, {(32 - ANGLE_BITS){1'b0}}};
   assign half_angle = {angle32[31], angle32[31:1]};
   assign init_angle = {init_heading_ff, 16'b0};

   // shared multiplier
   assign prod_in = mul_a * mul_b;

   // shared rounding shifter
   always_comb begin
      rnd_sh      = (state_ff == ST_RND_HEAD) ? HEAD_SHIFT : POS_SHIFT;
      rnd_half    = 67'(1) << (rnd_sh - 6'd1);
      rnd_neg     = {66'b0, prod_ff[66]};
      rnd_sum     = prod_ff + rnd_half - rnd_neg;
      rnd_shifted = rnd_sum >>> rnd_sh;
      rnd_in      = rnd_shifted[33:0];
   end

   // shared position accumulator with saturation
   always_comb begin
      acc_base = (state_ff == ST_ACC_Y) ? 34'(y_ff) : 34'(x_ff);
      acc_sum  = acc_base + rnd_ff;
      if (acc_sum[33:31] == {3{acc_sum[33]}}) begin
         acc_sat = acc_sum[31:0];
      end else if (acc_sum[33]) begin
         acc_sat = POS_MIN;
      end else begin
         acc_sat = POS_MAX;
      end
   end

   // csr writes
   always_comb begin
      time_step_in    = time_step_ff;
      init_x_in       = init_x_ff;
      init_y_in       = init_y_ff;
      init_heading_in = init_heading_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TIME_STEP:       time_step_in    = csr_data[15:0];
            CSR_INITIAL_X:       init_x_in       = csr_data;
            CSR_INITIAL_Y:       init_y_in       = csr_data;
            CSR_INITIAL_HEADING: init_heading_in = csr_data[15:0];
            default:             ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      w_in          = w_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      heading_in    = heading_ff;
      vdt_in        = vdt_ff;
      mul_en        = 1'b0;
      mul_a         = 33'(v_ff);
      mul_b         = signed'({18'b0, time_step_ff});
      cor_ctl.start = 1'b0;
      cor_ctl.angle = (state_ff == ST_COR_QUAT) ? half_angle : angle32;
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  v_in       = '0;
                  w_in       = '0;
                  x_in       = init_x_ff;
                  y_in       = init_y_ff;
                  heading_in = init_angle[31 -: ANGLE_BITS];
                  state_in   = ST_COR_QUAT;
               end else begin
                  v_in     = req_linear_velocity;
                  w_in     = req_angular_velocity;
                  state_in = ST_MUL_WDT;
               end
            end
         end
         ST_MUL_WDT: begin
            mul_en   = 1'b1;
            mul_a    = 33'(w_ff);
            state_in = ST_MUL_HEAD;
         end
         ST_MUL_HEAD: begin
            mul_en   = 1'b1;
            mul_a    = 33'(signed'(prod_ff[31:0]));
            mul_b    = 34'(HEAD_SCALE);
            state_in = ST_RND_HEAD;
         end
         ST_RND_HEAD: begin
            state_in = ST_UPD_HEAD;
         end
         ST_UPD_HEAD: begin
            // wraps modulo one turn
            heading_in = heading_ff + rnd_ff[ANGLE_BITS-1:0];
            state_in   = ST_COR_POSE;
         end
         ST_COR_POSE: begin
            cor_ctl.start = 1'b1;
            mul_en        = 1'b1;
            state_in      = ST_WAIT_POSE;
         end
         ST_WAIT_POSE: begin
            if (cor_sts.done) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            vdt_in   = prod_ff[31:0];
            mul_en   = 1'b1;
            mul_a    = 33'(signed'(prod_ff[31:0]));
            mul_b    = cor_cos;
            state_in = ST_RND_X;
         end
         ST_RND_X: begin
            state_in = ST_ACC_X;
         end
         ST_ACC_X: begin
            x_in     = acc_sat;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            mul_en   = 1'b1;
            mul_a    = 33'(vdt_ff);
            mul_b    = cor_sin;
            state_in = ST_RND_Y;
         end
         ST_RND_Y: begin
            state_in = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            y_in     = acc_sat;
            state_in = ST_COR_QUAT;
         end
         ST_COR_QUAT: begin
            cor_ctl.start = 1'b1;
            state_in      = ST_WAIT_QUAT;
         end
         ST_WAIT_QUAT: begin
            if (cor_sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state, csr and pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         time_step_ff    <= TIME_STEP_RESET;
         init_x_ff       <= '0;
         init_y_ff       <= '0;
         init_heading_ff <= '0;
         x_ff            <= '0;
         y_ff            <= '0;
         heading_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         time_step_ff    <= time_step_in;
         init_x_ff       <= init_x_in;
         init_y_ff       <= init_y_in;
         init_heading_ff <= init_heading_in;
         x_ff            <= x_in;
         y_ff            <= y_in;
         heading_ff      <= heading_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      w_ff   <= w_in;
      vdt_ff <= vdt_in;
      rnd_ff <= rnd_in;
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (out_load) begin
         out_x_ff       <= x_ff;
         out_y_ff       <= y_ff;
         out_heading_ff <= angle32[31:16];
         out_qz_ff      <= to_q15(cor_sin);
         out_qw_ff      <= to_q15(cor_cos);
         out_v_ff       <= v_ff;
         out_w_ff       <= w_ff;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_pos_x                 = out_x_ff;
   assign rsp_pos_y                 = out_y_ff;
   assign rsp_heading               = out_heading_ff;
   assign rsp_quat_z                = out_qz_ff;
   assign rsp_quat_w                = out_qw_ff;
   assign rsp_velocity_echo_linear  = out_v_ff;
   assign rsp_velocity_echo_angular = out_w_ff;

`ifndef SYNTHESIS
   // cordic finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      cor_sts.done |-> (state_ff == ST_WAIT_POSE || state_ff == ST_WAIT_QUAT))
      else $error("cordic done outside a wait state");

   // cordic is never restarted while running
   assert property (@(posedge clock) disable iff (reset)
      cor_ctl.start |-> !cor_sts.busy)
      else $error("cordic started while busy");

   // a load request takes the initial pose
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_LOAD) |=> (x_ff == $past(init_x_ff) &&
                                          y_ff == $past(init_y_ff)))
      else $error("load request did not take initial pose");

   // x moves only on its accumulate step or a load
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACC_X && !accept) |=> $stable(x_ff))
      else $error("x position changed outside its update step");

   // a handed-over result is shown and the sequencer is idle again
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result hand-over failed");
`endif

endmodule
